@@ src/fp4g_pkg.sv @@
// ----------------------------------------------------------------------------
// fp4g_pkg
// Shared constants, types and E2M1 decode helpers for the FP4 GEMV core.
// ----------------------------------------------------------------------------
package fp4g_pkg;

  localparam int COLUMNS_DEF   = 2048;
  localparam int SUM_WIDTH_DEF = 32;

  localparam int CODE_W    = 4;
  localparam int COL_W     = 11;
  localparam int DOT_W     = 32;
  localparam int VAL_W     = 5;   // doubled E2M1 value, -12..12
  localparam int PROD_W    = 10;  // product, -144..144
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  // doubled E2M1 magnitudes, indexed by code bits 2..0
  localparam logic [3:0] E2M1_MAG [8] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd12};

  typedef struct packed {
    logic [DOT_W-1:0] dot_sum;
    logic [COL_W-1:0] column;
  } res_t;

  function automatic logic signed [VAL_W-1:0] e2m1_value(logic [CODE_W-1:0] code);
    logic signed [VAL_W-1:0] mag;
    mag = signed'({1'b0, E2M1_MAG[code[2:0]]});
    return code[3] ? -mag : mag;
  endfunction

  function automatic logic signed [PROD_W-1:0] e2m1_product(logic [CODE_W-1:0] a,
                                                            logic [CODE_W-1:0] w);
    logic signed [PROD_W-1:0] va;
    logic signed [PROD_W-1:0] vw;
    va = PROD_W'(e2m1_value(a));
    vw = PROD_W'(e2m1_value(w));
    return va * vw;
  endfunction

endpackage

@@ src/fp4g_ram.sv @@
// ----------------------------------------------------------------------------
// fp4g_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fp4g_ram #(
  parameter int WIDTH = fp4g_pkg::SUM_WIDTH_DEF,
  parameter int DEPTH = fp4g_pkg::COLUMNS_DEF,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/fp4g_out_fifo.sv @@
// ----------------------------------------------------------------------------
// fp4g_out_fifo
// Small result queue that decouples the accumulate stage from the output.
// ----------------------------------------------------------------------------
module fp4g_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  fp4g_pkg::res_t                 push_data,
  input  logic                           pop,
  output logic                           not_empty,
  output fp4g_pkg::res_t                 head,
  output logic [fp4g_pkg::OUT_CNT_W-1:0] count
);

  fp4g_pkg::res_t                 slot_r [fp4g_pkg::OUT_DEPTH];
  logic [fp4g_pkg::OUT_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fp4g_pkg::OUT_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fp4g_pkg::OUT_CNT_W-1:0] count_r, count_nxt;
  logic                           do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + {{(fp4g_pkg::OUT_CNT_W-1){1'b0}}, push}
                         - {{(fp4g_pkg::OUT_CNT_W-1){1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];
  assign count     = count_r;

endmodule

@@ src/fp4_e2m1_gemv_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// fp4_e2m1_gemv_accumulator_core
// FP4 (E2M1) vector-times-matrix accumulator with one sum per output column.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                 | tuser      | tlast
//  --------+-----+-------------------------------------------+------------+----------
//  in_     | in  | act_code[3:0] weight_code[7:4] column[18:8] | first_term | last_term
//  out_    | out | out_column[10:0] dot_sum[42:11]           | -          | -
//
//  One transaction is accepted per cycle while in_tready is high. A
//  transaction reads its column sum from the RAM in the accept cycle, adds
//  its product in the next cycle and writes the sum back; a column written in
//  the previous cycle is forwarded. A column total is registered in the
//  accumulate stage, then enters the output queue, which raises out_tvalid.
//  Reset (rst_n low, synchronous) clears the pipeline and the output queue;
//  the sum RAM is not cleared, a first mark starts each column sum.
//  in_tready drops only when the output queue may fill up under stall.
//  Columns at or above COLUMNS are dropped without a result.
//
module fp4_e2m1_gemv_accumulator_core #(
  parameter int COLUMNS   = fp4g_pkg::COLUMNS_DEF,
  parameter int SUM_WIDTH = fp4g_pkg::SUM_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // act_code[3:0], weight_code[7:4], column[18:8], zero fill [23:19]
  input  logic [fp4g_pkg::IN_DATA_W-1:0]   in_tdata,
  // first_term[0]
  input  logic                             in_tuser,
  input  logic                             in_tlast,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // out_column[10:0], dot_sum[42:11], zero fill [47:43]
  output logic [fp4g_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready
);

  localparam int ADDR_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  // unpack the input transaction
  logic [fp4g_pkg::CODE_W-1:0] act_code;
  logic [fp4g_pkg::CODE_W-1:0] weight_code;
  logic [fp4g_pkg::COL_W-1:0]  column;
  logic                        accept;
  logic                        in_range;

  assign act_code    = in_tdata[3:0];
  assign weight_code = in_tdata[7:4];
  assign column      = in_tdata[18:8];
  assign accept      = in_tvalid && in_tready;
  assign in_range    = (32'(column) < COLUMNS);

  // accumulate stage
  logic                             s1_valid_r;
  logic                             s1_first_r;
  logic                             s1_last_r;
  logic [fp4g_pkg::COL_W-1:0]       s1_col_r;
  logic signed [fp4g_pkg::PROD_W-1:0] s1_prod_r;

  // forwarding copy of the last write
  logic                 fwd_valid_r;
  logic [fp4g_pkg::COL_W-1:0] fwd_col_r;
  logic [SUM_WIDTH-1:0] fwd_sum_r;

  logic [SUM_WIDTH-1:0] rd_data;
  logic [SUM_WIDTH-1:0] base_sum;
  logic [SUM_WIDTH-1:0] new_sum;

  fp4g_ram #(
    .WIDTH (SUM_WIDTH),
    .DEPTH (COLUMNS),
    .ADDR_W(ADDR_W)
  ) u_sum_ram (
    .clk    (clk),
    .wr_en  (s1_valid_r),
    .wr_addr(ADDR_W'(s1_col_r)),
    .wr_data(new_sum),
    .rd_en  (accept),
    .rd_addr(ADDR_W'(column)),
    .rd_data(rd_data)
  );

  // pick the running sum: restart, forwarded write or RAM copy
  always_comb begin
    if (s1_first_r) begin
      base_sum = '0;
    end else if (fwd_valid_r && (fwd_col_r == s1_col_r)) begin
      base_sum = fwd_sum_r;
    end else begin
      base_sum = rd_data;
    end
    new_sum = base_sum + SUM_WIDTH'(s1_prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= accept && in_range;
      fwd_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= in_tuser;
    s1_last_r  <= in_tlast;
    s1_col_r   <= column;
    s1_prod_r  <= fp4g_pkg::e2m1_product(act_code, weight_code);
    fwd_col_r  <= s1_col_r;
    fwd_sum_r  <= new_sum;
  end

  // result queue
  fp4g_pkg::res_t                 push_data;
  fp4g_pkg::res_t                 head;
  logic                           push;
  logic [fp4g_pkg::OUT_CNT_W-1:0] q_count;
  logic [fp4g_pkg::OUT_CNT_W-1:0] q_demand;

  assign push              = s1_valid_r && s1_last_r;
  assign push_data.column  = s1_col_r;
  assign push_data.dot_sum = fp4g_pkg::DOT_W'(signed'(new_sum));

  fp4g_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .pop      (out_tready),
    .not_empty(out_tvalid),
    .head     (head),
    .count    (q_count)
  );

  // hold off input once queued plus in-flight results could overrun the queue
  assign q_demand  = q_count + {{(fp4g_pkg::OUT_CNT_W-1){1'b0}}, push};
  assign in_tready = (q_demand <= fp4g_pkg::OUT_CNT_W'(fp4g_pkg::OUT_DEPTH - 1));

  assign out_tdata = {5'b0, head.dot_sum, head.column};

endmodule

@@ tb/fp4_e2m1_gemv_accumulator_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fp4_e2m1_gemv_accumulator_core_tb
// Self-checking bench for the FP4 (E2M1) GEMV accumulator core. A short table
// of directed terms covers code extremes, negative zero, single-term dot
// products and interleaved columns. Random interleaved dot products and
// loose terms follow. Every accepted transaction updates a local model of
// the column sums; each total is checked in order against it or a typed answer.
// ----------------------------------------------------------------------------
module fp4_e2m1_gemv_accumulator_core_tb;

  localparam int CODE_W      = fp4g_pkg::CODE_W;
  localparam int COL_W       = fp4g_pkg::COL_W;
  localparam int DOT_W       = fp4g_pkg::DOT_W;
  localparam int IN_DATA_W   = fp4g_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = fp4g_pkg::OUT_DATA_W;
  localparam int N_COLS      = fp4g_pkg::COLUMNS_DEF;
  localparam int ITEM_TARGET = 1850;
  localparam int CALM_START  = 400;   // no idling on either side in this span
  localparam int CALM_STOP   = 700;
  localparam int DRAIN_AT    = 1000;  // sender holds off here until all totals drain
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYC  = 20;

  // doubled E2M1 magnitudes, indexed by code bits 2..0
  localparam int TWICE_MAG [8] = '{0, 1, 2, 3, 4, 6, 8, 12};

  typedef struct {
    logic [COL_W-1:0] col;
    logic [DOT_W-1:0] total;
  } col_total_t;

  typedef struct {
    logic [CODE_W-1:0] act;
    logic [CODE_W-1:0] wt;
    logic [COL_W-1:0]  col;
    bit                first;
    bit                last;
    bit                typed;   // 1: total below is the known answer
    int                total;
  } term_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  in_tlast = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;

  // local copy of the per-column sums and which ones a first mark has opened
  logic [DOT_W-1:0] col_sum_model [N_COLS];
  bit               col_opened [N_COLS];
  col_total_t       pending_totals [$];

  int  err_cnt = 0;
  int  item_cnt = 0;
  int  cycle_cnt = 0;
  bit  calm = 1'b0;
  bit  drained_once = 1'b0;
  int  recent_col = 0;

  // Directed terms. Each column opens with a first mark before any plain term.
  term_row_t directed_terms [18] = '{
    '{7,  7,  0,    1, 1, 1, 144},   // largest positive product
    '{15, 7,  2047, 1, 1, 1, -144},  // top column, most negative product
    '{8,  15, 1,    1, 1, 1, 0},     // negative zero times -12
    '{0,  0,  2,    1, 1, 1, 0},     // plain zero
    '{15, 15, 3,    1, 1, 1, 144},   // two negatives
    '{10, 13, 1365, 1, 1, 1, 12},    // alternating column bits
    '{11, 4,  682,  1, 1, 1, -12},   // complementary column bits
    '{1,  1,  1024, 1, 0, 0, 0},     // open a three-term sum
    '{9,  2,  1024, 0, 0, 0, 0},
    '{5,  12, 1024, 0, 1, 0, 0},
    '{4,  3,  1024, 0, 1, 0, 0},     // keep adding after a total went out
    '{6,  6,  5,    1, 0, 0, 0},     // two columns interleaved
    '{14, 6,  6,    1, 0, 0, 0},
    '{2,  3,  5,    0, 1, 0, 0},
    '{3,  11, 6,    0, 1, 0, 0},
    '{7,  15, 0,    1, 0, 0, 0},     // restart a column with a first mark
    '{8,  0,  0,    0, 0, 0, 0},
    '{12, 9,  0,    0, 1, 0, 0}
  };

  fp4_e2m1_gemv_accumulator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  always #5 clk = ~clk;

  // Bound the run; a hang or a lost total ends up here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("fp4_e2m1_gemv_accumulator_core verification failed");
      $finish;
    end
  end

  // Stall the result side about a third of the time, except in the calm span.
  always @(posedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 33);
  end

  function automatic int twice_value(logic [CODE_W-1:0] code);
    int mag;
    mag = TWICE_MAG[code[2:0]];
    return code[3] ? -mag : mag;
  endfunction

  // Fold one accepted term into the column sum; report a total on a last mark.
  task automatic accumulate_term(input logic [CODE_W-1:0] act, input logic [CODE_W-1:0] wt,
                                 input logic [COL_W-1:0] col, input bit first,
                                 input bit last, output bit done,
                                 output logic [DOT_W-1:0] total);
    logic [DOT_W-1:0] acc;
    int               prod;
    prod = twice_value(act) * twice_value(wt);
    acc = first ? '0 : col_sum_model[col];
    acc = acc + DOT_W'(prod);   // wraps modulo 2^32
    col_sum_model[col] = acc;
    col_opened[col] = 1'b1;
    done = last;
    total = acc;
  endtask

  // Compare each result transaction against the oldest pending total.
  always @(posedge clk) begin
    col_total_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_totals.size() == 0) begin
        $error("result with no pending total: column %0d sum %0d",
               out_tdata[COL_W-1:0], $signed(out_tdata[COL_W+DOT_W-1:COL_W]));
        err_cnt++;
      end else begin
        want = pending_totals.pop_front();
        if (out_tdata[COL_W-1:0] !== want.col) begin
          $error("out_column: expected %0d, got %0d", want.col, out_tdata[COL_W-1:0]);
          err_cnt++;
        end
        if (out_tdata[COL_W+DOT_W-1:COL_W] !== want.total) begin
          $error("dot_sum: expected %0d, got %0d", $signed(want.total),
                 $signed(out_tdata[COL_W+DOT_W-1:COL_W]));
          err_cnt++;
        end
        if (out_tdata[OUT_DATA_W-1:COL_W+DOT_W] !== '0) begin
          $error("out_tdata fill: expected 0, got %0h",
                 out_tdata[OUT_DATA_W-1:COL_W+DOT_W]);
          err_cnt++;
        end
      end
    end
  end

  // Present one term, hold it until accepted, then record its total, if any.
  // A typed total replaces the model's answer for rows that carry one.
  task automatic send_term(input logic [CODE_W-1:0] act, input logic [CODE_W-1:0] wt,
                           input logic [COL_W-1:0] col, input bit first, input bit last,
                           input bit typed, input logic [DOT_W-1:0] typed_total);
    bit               done;
    logic [DOT_W-1:0] total;
    col_total_t       entry;
    in_tdata  <= {{(IN_DATA_W-COL_W-2*CODE_W){1'b0}}, col, wt, act};
    in_tuser  <= first;
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    accumulate_term(act, wt, col, first, last, done, total);
    if (done) begin
      entry.col = col;
      entry.total = typed ? typed_total : total;
      pending_totals = {pending_totals, entry};
    end
    item_cnt++;
    calm = (item_cnt >= CALM_START) && (item_cnt < CALM_STOP);
    // Idle about a third of the cycles; scramble the bus while invalid.
    while (!calm && ($urandom_range(99) < 33)) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {{(IN_DATA_W-COL_W-2*CODE_W){1'b0}}, (COL_W+2*CODE_W)'($urandom)};
      in_tuser  <= 1'($urandom_range(1));
      in_tlast  <= 1'($urandom_range(1));
      @(posedge clk);
    end
  endtask

  // One to four dot products on distinct-or-not columns, terms interleaved at random.
  task automatic run_dot_products();
    int n_seq;
    int seq_col [4];
    int seq_len [4];
    int seq_pos [4];
    int left;
    int pick;
    left = 0;
    n_seq = $urandom_range(1, 4);
    for (int s = 0; s < n_seq; s++) begin
      seq_col[s] = $urandom_range(N_COLS - 1);
      seq_len[s] = ($urandom_range(15) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      seq_pos[s] = 0;
      left += seq_len[s];
    end
    recent_col = seq_col[0];
    while (left > 0) begin
      pick = $urandom_range(n_seq - 1);
      while (seq_pos[pick] == seq_len[pick]) pick = (pick + 1) % n_seq;
      send_term(CODE_W'($urandom_range(15)), CODE_W'($urandom_range(15)),
                COL_W'(seq_col[pick]),
                seq_pos[pick] == 0, seq_pos[pick] == seq_len[pick] - 1, 1'b0, '0);
      seq_pos[pick]++;
      left--;
    end
  endtask

  // A loose term; never read a column that no first mark has opened.
  task automatic send_loose_term();
    int col;
    bit first;
    col = $urandom_range(1) ? recent_col : $urandom_range(N_COLS - 1);
    first = col_opened[col] ? bit'($urandom_range(3) == 0) : 1'b1;
    send_term(CODE_W'($urandom_range(15)), CODE_W'($urandom_range(15)), COL_W'(col),
              first, 1'($urandom_range(1)), 1'b0, '0);
  endtask

  initial begin
    for (int c = 0; c < N_COLS; c++) begin
      col_sum_model[c] = '0;
      col_opened[c] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_terms[i]) begin
      send_term(directed_terms[i].act, directed_terms[i].wt, directed_terms[i].col,
                directed_terms[i].first, directed_terms[i].last,
                directed_terms[i].typed, DOT_W'(directed_terms[i].total));
    end

    while (item_cnt < ITEM_TARGET) begin
      if ($urandom_range(99) < 85) run_dot_products();
      else send_loose_term();
      // Hold off once until every pending total has come back.
      if (!drained_once && item_cnt >= DRAIN_AT) begin
        drained_once = 1'b1;
        in_tvalid <= 1'b0;
        wait (pending_totals.size() == 0);
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b0;

    wait (pending_totals.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("fp4_e2m1_gemv_accumulator_core verification clean");
    end else begin
      $display("fp4_e2m1_gemv_accumulator_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/fp4g_pkg.sv
src/fp4g_ram.sv
src/fp4g_out_fifo.sv
src/fp4_e2m1_gemv_accumulator_core.sv
tb/fp4_e2m1_gemv_accumulator_core_tb.sv
